/* rtl/core/script_token_lexer_top_macros.svh */
// Assertion macros shared by the lexer RTL.
`ifndef SCRIPT_TOKEN_LEXER_TOP_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_TOP_MACROS_SVH

// prop must hold at every clock edge outside reset
`define STL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// cond must never be seen outside reset
`define STL_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/stl_pkg.sv */
// Shared types and constants of the script token lexer.
package stl_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int LINE_WIDTH_DEF  = 32;
	localparam int OUT_FIELD_W     = 32;
	localparam int MID_DEPTH       = 2;
	localparam int OUT_DEPTH       = 2;

	localparam logic [3:0] K_NUMBER = 4'd0;
	localparam logic [3:0] K_STRING = 4'd1;
	localparam logic [3:0] K_ID     = 4'd2;
	localparam logic [3:0] K_EQUAL  = 4'd3;
	localparam logic [3:0] K_COLON  = 4'd4;
	localparam logic [3:0] K_SEMI   = 4'd5;
	localparam logic [3:0] K_LBRACE = 4'd6;
	localparam logic [3:0] K_RBRACE = 4'd7;
	localparam logic [3:0] K_LPAREN = 4'd8;
	localparam logic [3:0] K_RPAREN = 4'd9;
	localparam logic [3:0] K_DOT    = 4'd10;
	localparam logic [3:0] K_EOF    = 4'd11;
	localparam logic [3:0] K_ERROR  = 4'd12;

	typedef enum logic [3:0] {
		CC_OTHER  = 4'd0,
		CC_NL     = 4'd1,
		CC_WS     = 4'd2,
		CC_PUNCT  = 4'd3,
		CC_DOT    = 4'd4,
		CC_SLASH  = 4'd5,
		CC_STAR   = 4'd6,
		CC_QUOTE  = 4'd7,
		CC_MINUS  = 4'd8,
		CC_DIGIT  = 4'd9,
		CC_HEXLET = 4'd10,
		CC_X      = 4'd11,
		CC_ALPHA  = 4'd12
	} cclass_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} item_t;

	// classified character as it travels from front to back
	typedef struct packed {
		logic       eoi;
		logic [7:0] ch;
		cclass_t    cls;
		logic [3:0] punct_kind;
		logic [3:0] digit;
	} citem_t;

	typedef struct packed {
		logic [3:0]             token_kind;
		logic [7:0]             text_byte;
		logic                   text_valid;
		logic                   token_done;
		logic [OUT_FIELD_W-1:0] hex_value;
		logic                   hex_valid;
		logic [OUT_FIELD_W-1:0] line_number;
		logic                   last_of_item;
	} result_t;

endpackage

/* rtl/core/script_token_lexer_top.sv */
// Script token lexer top level: classifier front, queue, lexer back, result queue.
//
// Input channel: present a character (or the end-of-input mark) on item and raise
// push; the word is taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result word sits on result; it is
// taken at a clock edge where pop is high and empty is low.
// Each character gives zero, one or two result words; last_of_item marks the final
// word that a character caused. Token text comes one byte per word, closed by a
// word with token_done set.
// Path: a character is registered in the middle queue, the lexer back end handles it
// combinationally, and its result words are registered in the result queue for popping.
// Throughput: one character per cycle when it gives at most one word and the result
// queue is not full; a character that gives two words holds the lexer until its second
// word, kept in pend, is pushed, since the result queue takes one word per cycle.
// When the receiver stops popping, the result queue fills, the lexer holds, the
// middle queue fills and full rises; nothing is lost.
// Reset (arst_n low) empties both queues, returns the lexer to between-token state
// and clears the line count.
module script_token_lexer_top import stl_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int LINE_WIDTH  = LINE_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   item,
	output logic    full,
	input  logic    pop,
	output result_t result,
	output logic    empty
);

	citem_t  front_item;
	citem_t  mid_item;
	logic    mid_empty;
	logic    mid_pop;
	logic    out_full;
	logic    out_push;
	result_t out_data;

	stl_front u_front (
		.item  (item),
		.citem (front_item)
	);

	stl_fifo #(
		.WIDTH ($bits(citem_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	stl_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.LINE_WIDTH  (LINE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (!mid_empty),
		.mid_item  (mid_item),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	stl_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_data),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

/* rtl/core/stl_fifo.sv */
// Small register queue used between lexer stages and on the result side.
module stl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

`include "script_token_lexer_top_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	`STL_NEVER(a_count_bound, count_q > CW'(DEPTH), "queue count above depth")
	`STL_NEVER(a_full_empty, full && empty, "queue full and empty at once")
	`STL_ASSERT(a_pop_frees, (do_pop && !do_push) |=> !full, "pop did not free an entry")

endmodule

/* rtl/core/stl_front.sv */
// Front stage: sorts each incoming character into a lexical class.
module stl_front import stl_pkg::*; (
	input  item_t  item,
	output citem_t citem
);

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_X_UP   = 8'h58;

	logic [7:0] c;
	logic       is_dig;
	logic       is_hexlet;
	logic       is_alpha;

	assign c         = item.in_byte;
	assign is_dig    = (c >= 8'h30) && (c <= 8'h39);
	assign is_hexlet = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	assign is_alpha  = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
		|| (c == CH_UNDER);

	always_comb begin
		citem.eoi        = item.end_of_input;
		citem.ch         = c;
		citem.punct_kind = K_NUMBER;
		// letters a-f/A-F have low nibble 1..6
		citem.digit      = is_dig ? c[3:0] : c[3:0] + 4'd9;
		citem.cls        = CC_OTHER;
		case (c)
			CH_NL: begin
				citem.cls = CC_NL;
			end
			CH_TAB, CH_CR, CH_SPACE: begin
				citem.cls = CC_WS;
			end
			CH_EQUAL: begin
				citem.cls        = CC_PUNCT;
				citem.punct_kind = K_EQUAL;
			end
			CH_COLON: begin
				citem.cls        = CC_PUNCT;
				citem.punct_kind = K_COLON;
			end
			CH_SEMI: begin
				citem.cls        = CC_PUNCT;
				citem.punct_kind = K_SEMI;
			end
			CH_LBRACE: begin
				citem.cls        = CC_PUNCT;
				citem.punct_kind = K_LBRACE;
			end
			CH_RBRACE: begin
				citem.cls        = CC_PUNCT;
				citem.punct_kind = K_RBRACE;
			end
			CH_LPAREN: begin
				citem.cls        = CC_PUNCT;
				citem.punct_kind = K_LPAREN;
			end
			CH_RPAREN: begin
				citem.cls        = CC_PUNCT;
				citem.punct_kind = K_RPAREN;
			end
			CH_DOT: begin
				citem.cls        = CC_DOT;
				citem.punct_kind = K_DOT;
			end
			CH_SLASH: begin
				citem.cls = CC_SLASH;
			end
			CH_STAR: begin
				citem.cls = CC_STAR;
			end
			CH_QUOTE: begin
				citem.cls = CC_QUOTE;
			end
			CH_MINUS: begin
				citem.cls = CC_MINUS;
			end
			CH_X_LO, CH_X_UP: begin
				citem.cls = CC_X;
			end
			default: begin
				if (is_dig) begin
					citem.cls = CC_DIGIT;
				end else if (is_hexlet) begin
					citem.cls = CC_HEXLET;
				end else if (is_alpha) begin
					citem.cls = CC_ALPHA;
				end else begin
					citem.cls = CC_OTHER;
				end
			end
		endcase
	end

endmodule

/* rtl/core/stl_back.sv */
// Back stage: lexer state machine, hex conversion, line count and result issue.
module stl_back import stl_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int LINE_WIDTH  = LINE_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    mid_valid,
	input  citem_t  mid_item,
	output logic    mid_pop,
	input  logic    out_full,
	output logic    out_push,
	output result_t out_data
);

`include "script_token_lexer_top_macros.svh"

	localparam int VW  = VALUE_WIDTH;
	localparam int HW  = (VW > OUT_FIELD_W) ? VW : OUT_FIELD_W;
	localparam int LHW = (LINE_WIDTH > OUT_FIELD_W) ? LINE_WIDTH : OUT_FIELD_W;

	typedef enum logic [8:0] {
		M_IDLE     = 9'b000000001,
		M_SLASH    = 9'b000000010,
		M_LCOM     = 9'b000000100,
		M_BCOM     = 9'b000001000,
		M_BSTAR    = 9'b000010000,
		M_STR      = 9'b000100000,
		M_NUMFIRST = 9'b001000000,
		M_NUM      = 9'b010000000,
		M_ID       = 9'b100000000
	} mode_t;

	typedef struct packed {
		logic       emit;
		logic [3:0] kind;
		logic [7:0] text;
		logic       tv;
		logic       done;
		mode_t      mode;
		logic       bump;
		logic       num_start;
		logic       neg;
	} idle_t;

	// what a character does between tokens; also used when a character is taken again
	function automatic idle_t idle_step(input citem_t it);
		idle_t o;
		o      = idle_t'('0);
		o.mode = M_IDLE;
		if (it.eoi) begin
			o.emit = 1'b1;
			o.kind = K_EOF;
			o.done = 1'b1;
		end else begin
			case (it.cls)
				CC_NL: begin
					o.bump = 1'b1;
				end
				CC_PUNCT, CC_DOT: begin
					o.emit = 1'b1;
					o.kind = it.punct_kind;
					o.text = it.ch;
					o.tv   = 1'b1;
					o.done = 1'b1;
				end
				CC_SLASH: begin
					o.mode = M_SLASH;
				end
				CC_QUOTE: begin
					o.mode = M_STR;
				end
				CC_MINUS, CC_DIGIT: begin
					o.emit      = 1'b1;
					o.kind      = K_NUMBER;
					o.text      = it.ch;
					o.tv        = 1'b1;
					o.num_start = 1'b1;
					o.neg       = (it.cls == CC_MINUS);
					o.mode      = M_NUMFIRST;
				end
				CC_HEXLET, CC_X, CC_ALPHA: begin
					o.emit = 1'b1;
					o.kind = K_ID;
					o.text = it.ch;
					o.tv   = 1'b1;
					o.mode = M_ID;
				end
				default: begin
					o.emit = 1'b0;
				end
			endcase
		end
		return o;
	endfunction

	mode_t                 mode_q, mode_n;
	logic                  seen_q, seen_n;
	logic                  hex_q, hex_n;
	logic                  any_q, any_n;
	logic                  neg_q, neg_n;
	logic [VW-1:0]         acc_q, acc_n;
	logic [LINE_WIDTH-1:0] line_q;
	logic                  pend_q;
	result_t               pend_data_q;

	idle_t                 idle;
	citem_t                it;
	logic                  e;
	logic                  take;
	logic                  r0v, r1v, reproc, do_num, fin, clr, bump;
	logic [3:0]            r0_kind;
	logic [7:0]            r0_text;
	logic                  r0_tv, r0_done, r0_hv;
	logic [OUT_FIELD_W-1:0] r0_hex;
	logic [VW-1:0]         half, limit, cap, acc_sat, hex_val;
	logic [VW+3:0]         acc_next;
	logic [HW-1:0]         hex_wide;
	logic [LHW-1:0]        line_wide;
	result_t               res0, res1, first;

	assign it   = mid_item;
	assign e    = it.eoi;
	assign idle = idle_step(it);

	// hex magnitude saturates one above the limit so overflow is sticky
	assign half     = {1'b1, {(VW - 1){1'b0}}};
	assign limit    = neg_q ? half : half - 1'b1;
	assign cap      = limit + 1'b1;
	assign acc_next = ({4'b0, acc_q} << 4) | (VW + 4)'(it.digit);
	assign acc_sat  = (acc_next > (VW + 4)'(cap)) ? cap : acc_next[VW-1:0];
	assign hex_val  = neg_q ? ('0 - acc_q) : acc_q;
	assign hex_wide = HW'(hex_val);

	always_comb begin
		r0v     = 1'b0;
		r0_kind = K_NUMBER;
		r0_text = '0;
		r0_tv   = 1'b0;
		r0_done = 1'b0;
		r0_hex  = '0;
		r0_hv   = 1'b0;
		reproc  = 1'b0;
		do_num  = 1'b0;
		fin     = 1'b0;
		clr     = 1'b0;
		bump    = 1'b0;
		mode_n  = mode_q;
		seen_n  = seen_q;
		hex_n   = hex_q;
		any_n   = any_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		case (mode_q)
			M_IDLE: begin
				r0v     = idle.emit;
				r0_kind = idle.kind;
				r0_text = idle.text;
				r0_tv   = idle.tv;
				r0_done = idle.done;
				mode_n  = idle.mode;
				bump    = idle.bump;
			end
			M_SLASH: begin
				if (!e && it.cls == CC_SLASH) begin
					mode_n = M_LCOM;
				end else if (!e && it.cls == CC_STAR) begin
					mode_n = M_BCOM;
				end else begin
					r0v     = 1'b1;
					r0_kind = K_ERROR;
					r0_done = 1'b1;
					mode_n  = M_IDLE;
					reproc  = 1'b1;
				end
			end
			M_LCOM: begin
				if (e) begin
					mode_n = M_IDLE;
					reproc = 1'b1;
				end else if (it.cls == CC_NL) begin
					bump   = 1'b1;
					mode_n = M_IDLE;
				end
			end
			M_BCOM, M_BSTAR: begin
				if (e) begin
					mode_n = M_IDLE;
					reproc = 1'b1;
				end else if (it.cls == CC_STAR) begin
					mode_n = M_BSTAR;
				end else if (it.cls == CC_SLASH && mode_q == M_BSTAR) begin
					mode_n = M_IDLE;
				end else begin
					mode_n = M_BCOM;
					bump   = (it.cls == CC_NL);
				end
			end
			M_STR: begin
				if (e) begin
					r0v     = 1'b1;
					r0_kind = K_ERROR;
					r0_done = 1'b1;
					mode_n  = M_IDLE;
					reproc  = 1'b1;
				end else if (it.cls == CC_QUOTE) begin
					r0v     = 1'b1;
					r0_kind = K_STRING;
					r0_done = 1'b1;
					mode_n  = M_IDLE;
				end else begin
					r0v     = 1'b1;
					r0_kind = K_STRING;
					r0_text = it.ch;
					r0_tv   = 1'b1;
				end
			end
			M_NUMFIRST: begin
				if (!e && it.cls == CC_X) begin
					hex_n   = 1'b1;
					r0v     = 1'b1;
					r0_kind = K_NUMBER;
					r0_text = it.ch;
					r0_tv   = 1'b1;
					mode_n  = M_NUM;
				end else begin
					do_num = 1'b1;
				end
			end
			M_NUM: begin
				do_num = 1'b1;
			end
			M_ID: begin
				if (!e && (it.cls == CC_DIGIT || it.cls == CC_HEXLET || it.cls == CC_X
					|| it.cls == CC_ALPHA || it.cls == CC_MINUS)) begin
					r0v     = 1'b1;
					r0_kind = K_ID;
					r0_text = it.ch;
					r0_tv   = 1'b1;
				end else begin
					r0v     = 1'b1;
					r0_kind = K_ID;
					r0_done = 1'b1;
					mode_n  = M_IDLE;
					reproc  = 1'b1;
				end
			end
			default: begin
				mode_n = M_IDLE;
				reproc = 1'b1;
			end
		endcase

		if (do_num) begin
			mode_n = M_NUM;
			if (e) begin
				fin    = 1'b1;
				reproc = 1'b1;
			end else if (it.cls == CC_DOT) begin
				if (seen_q || hex_q) begin
					// bad dot is swallowed with the error
					r0v     = 1'b1;
					r0_kind = K_ERROR;
					r0_done = 1'b1;
					clr     = 1'b1;
				end else begin
					seen_n  = 1'b1;
					r0v     = 1'b1;
					r0_kind = K_NUMBER;
					r0_text = it.ch;
					r0_tv   = 1'b1;
				end
			end else if (it.cls == CC_DIGIT || (hex_q && it.cls == CC_HEXLET)) begin
				if (hex_q) begin
					acc_n = acc_sat;
					any_n = 1'b1;
				end
				r0v     = 1'b1;
				r0_kind = K_NUMBER;
				r0_text = it.ch;
				r0_tv   = 1'b1;
			end else begin
				fin    = 1'b1;
				reproc = 1'b1;
			end
		end

		if (fin) begin
			r0v     = 1'b1;
			r0_done = 1'b1;
			if (hex_q && (!any_q || acc_q > limit)) begin
				r0_kind = K_ERROR;
			end else if (hex_q) begin
				r0_kind = K_NUMBER;
				r0_hex  = hex_wide[OUT_FIELD_W-1:0];
				r0_hv   = 1'b1;
			end else begin
				r0_kind = K_NUMBER;
			end
			clr = 1'b1;
		end

		if (clr) begin
			seen_n = 1'b0;
			hex_n  = 1'b0;
			any_n  = 1'b0;
			neg_n  = 1'b0;
			acc_n  = '0;
			mode_n = M_IDLE;
		end

		r1v = 1'b0;
		if (reproc) begin
			r1v    = idle.emit;
			mode_n = idle.mode;
			bump   = bump | idle.bump;
		end

		if ((mode_q == M_IDLE || reproc) && idle.num_start) begin
			seen_n = 1'b0;
			hex_n  = 1'b0;
			any_n  = 1'b0;
			acc_n  = '0;
			neg_n  = idle.neg;
		end
	end

	assign line_wide = LHW'(line_q);

	always_comb begin
		res0.token_kind   = r0_kind;
		res0.text_byte    = r0_text;
		res0.text_valid   = r0_tv;
		res0.token_done   = r0_done;
		res0.hex_value    = r0_hex;
		res0.hex_valid    = r0_hv;
		res0.line_number  = line_wide[OUT_FIELD_W-1:0];
		res0.last_of_item = !r1v;
		res1.token_kind   = idle.kind;
		res1.text_byte    = idle.text;
		res1.text_valid   = idle.tv;
		res1.token_done   = idle.done;
		res1.hex_value    = '0;
		res1.hex_valid    = 1'b0;
		res1.line_number  = line_wide[OUT_FIELD_W-1:0];
		res1.last_of_item = 1'b1;
		first             = r0v ? res0 : res1;
	end

	// a second word of the same item waits in pend until the result queue has room
	assign take     = mid_valid && !pend_q && !out_full;
	assign mid_pop  = take;
	assign out_push = (pend_q && !out_full) || (take && (r0v || r1v));
	assign out_data = pend_q ? pend_data_q : first;

	always_ff @(posedge clk) begin
		if (take && r0v && r1v) begin
			pend_data_q <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			seen_q <= 1'b0;
			hex_q  <= 1'b0;
			any_q  <= 1'b0;
			neg_q  <= 1'b0;
			acc_q  <= '0;
			line_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= mode_n;
				seen_q <= seen_n;
				hex_q  <= hex_n;
				any_q  <= any_n;
				neg_q  <= neg_n;
				acc_q  <= acc_n;
				if (bump) begin
					line_q <= line_q + 1'b1;
				end
				pend_q <= r0v && r1v;
			end else if (pend_q && !out_full) begin
				pend_q <= 1'b0;
			end
		end
	end

	`STL_ASSERT(a_pend_blocks, pend_q |-> !take, "new character taken while a word is pending")
	`STL_ASSERT(a_pend_drain, (pend_q && !out_full) |=> !pend_q, "pending word not drained")
	`STL_ASSERT(a_push_room, out_push |-> !out_full, "result pushed into a full queue")
	`STL_ASSERT(a_hex_sat, hex_q |-> (acc_q <= cap), "hex magnitude above saturation")

endmodule
